[sv/btpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and node helpers for the buddy tree allocator.
// No dependencies; imported by the top level, the engine and the testbench.
package btpa_pkg;

  localparam int TREE_LEVELS = 10;
  localparam int PAGE_SHIFT  = 12;
  localparam int NODE_COUNT  = (1 << (TREE_LEVELS + 1)) - 1;
  localparam int IDX_W       = TREE_LEVELS + 1;
  localparam int DEPTH_W     = $clog2(TREE_LEVELS + 1);
  localparam int SZ_W        = 6;
  localparam logic [63:0] PAGE_BYTES = 64'(1) << PAGE_SHIFT;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_NOT_USED = 3'd2,
    ST_RESERVED = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    NODE_FREE = 2'd0,
    NODE_DIV  = 2'd1,
    NODE_USED = 2'd2,
    NODE_RSV  = 2'd3
  } node_st_t;

  typedef struct packed {
    node_st_t          st;
    logic [SZ_W-1:0]   sz;
  } node_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] alloc_bytes;
    logic [31:0] address;
    logic [31:0] range_end;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] block_address;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic res_take;
  } eng_ctl_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_sts_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_RCHK, S_DRD, S_DEVAL,
    S_AW0, S_AW1, S_AW2, S_ARDL, S_ARDR, S_ADEC,
    S_RW1, S_RW2, S_RACT,
    S_UST, S_URDR, S_UMRG, S_FIN
  } state_t;

  // free space a child offers to a request
  function automatic logic [63:0] node_avail(node_t v);
    logic [63:0] r;
    r = 64'(1) << v.sz;
    if (v.st == NODE_USED || v.st == NODE_RSV) r = '0;
    else if (v.st == NODE_DIV && v.sz == '0) r = '0;
    return r;
  endfunction

  // parent value recomputed from its two children
  function automatic node_t node_merge(node_t l, node_t r);
    node_t           m;
    logic [SZ_W-1:0] best;
    best = '0;
    if (l.st == NODE_FREE && r.st == NODE_FREE) begin
      m.st = NODE_FREE;
      m.sz = l.sz + SZ_W'(1);
    end else begin
      if (l.st == NODE_FREE || l.st == NODE_DIV) best = l.sz;
      if ((r.st == NODE_FREE || r.st == NODE_DIV) && r.sz > best) best = r.sz;
      m.st = NODE_DIV;
      m.sz = best;
    end
    return m;
  endfunction

endpackage

[sv/buddy_tree_page_allocator.sv]
`timescale 1ns / 1ps
// Buddy tree page allocator top level: config registers, request intake, result register.
// Alloc, free and a valid non-empty reserve walk the node store down and back up to the
//   root; init only writes the root, and a reserve whose range straddles a midpoint
//   walks two paths.
// Throughput: one request at a time, set by the tree walk through the node store.
// Reset: control and config registers cleared to defaults (base 0, shift 22); the
//   node store is undefined until an init command writes the root.
module buddy_tree_page_allocator (
  input  logic            clk,
  input  logic            rst,
  // request channel
  input  logic            req_valid,
  output logic            req_stall,
  input  btpa_pkg::req_t  req,
  // result channel
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output btpa_pkg::rsp_t  rsp,
  // configuration write channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data
);
  import btpa_pkg::*;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_SHIFT = 1'b1;

  logic [31:0] region_base;
  logic [5:0]  region_shift;
  eng_ctl_t    ctl;
  eng_sts_t    sts;
  rsp_t        eng_res;

  // The user must write configuration only while idle; the block does not enforce it, so always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      region_shift <= 6'd22;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE:  region_base  <= cfg_data;
        CFG_SHIFT: region_shift <= cfg_data[5:0];
      endcase
    end
  end

  // A request transfers whenever the sequencer is idle; a finished result may
  // still sit in the output register meanwhile.
  assign req_stall    = !sts.idle;
  assign ctl.start    = req_valid && !req_stall;
  assign ctl.res_take = sts.res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_take) begin
      rsp <= eng_res;
    end
  end

  btpa_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .item         (req),
    .region_base  (region_base),
    .region_shift (region_shift),
    .sts          (sts),
    .res          (eng_res)
  );

endmodule

[sv/btpa_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module btpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/btpa_engine.sv]
`timescale 1ns / 1ps
// Tree walk sequencer: descends and climbs the node store.
// Depends on btpa_pkg and btpa_ram.
module btpa_engine (
  input  logic                clk,
  input  logic                rst,
  input  btpa_pkg::eng_ctl_t  ctl,
  input  btpa_pkg::req_t      item,
  input  logic [31:0]         region_base,
  input  logic [5:0]          region_shift,
  output btpa_pkg::eng_sts_t  sts,
  output btpa_pkg::rsp_t      res
);
  import btpa_pkg::*;

  state_t state, state_next;

  cmd_t               cmd;
  status_t            status;
  logic [31:0]        need, addr_q, blk;
  logic [63:0]        lo, hi, b, e, span, mid, eb;
  logic [63:0]        split_mid, split_hi, split_e;
  logic [IDX_W-1:0]   idx, split_idx;
  logic [DEPTH_W-1:0] depth;
  logic               pending;
  node_t              nd_q, lnode;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  node_t              mem_wdata;
  logic [7:0]         mem_rdata;

  node_t              rnode, merged;
  logic [IDX_W-1:0]   lchild, rchild, parent;
  logic [63:0]        size64, need64, la, ra;
  logic               leaf_lvl, a_gt_size, a_take, la_fit, ra_fit;
  logic               r_leaf, r_claim, deval_up, up_go;
  state_t             up_tgt;

  btpa_ram #(.WIDTH(8), .DEPTH(NODE_COUNT)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rnode     = node_t'(mem_rdata);
  assign merged    = node_merge(lnode, rnode);
  assign lchild    = IDX_W'({idx, 1'b0} + (IDX_W + 1)'(1));
  assign rchild    = lchild + IDX_W'(1);
  assign parent    = IDX_W'((idx - IDX_W'(1)) >> 1);
  assign leaf_lvl  = depth >= DEPTH_W'(TREE_LEVELS);
  assign size64    = 64'(1) << rnode.sz;
  assign need64    = {32'b0, need};
  assign a_gt_size = need64 > size64;
  assign a_take    = !a_gt_size && (need64 > (size64 >> 1) ||
                     rnode.sz <= SZ_W'(PAGE_SHIFT) || leaf_lvl);
  assign la        = node_avail(lnode);
  assign ra        = node_avail(rnode);
  assign la_fit    = la >= need64;
  assign ra_fit    = ra >= need64;
  assign r_leaf    = span <= PAGE_BYTES || leaf_lvl;
  assign r_claim   = r_leaf || eb > (span >> 1);
  assign up_tgt    = (idx == '0) ? S_FIN : S_UST;

  always_comb begin
    deval_up = 1'b0;
    unique case (cmd)
      CMD_ALLOC: begin
        if (rnode.st == NODE_FREE) deval_up = a_gt_size || a_take;
        else if (rnode.st == NODE_DIV) deval_up = a_gt_size || leaf_lvl;
        else deval_up = 1'b1;
      end
      CMD_FREE:    deval_up = rnode.st != NODE_DIV || leaf_lvl;
      CMD_RESERVE: deval_up = rnode.st == NODE_USED || rnode.st == NODE_RSV;
      CMD_INIT:    deval_up = 1'b1;
    endcase
  end

  assign up_go = (state == S_DEVAL && deval_up) || (state == S_RACT && r_claim) ||
                 state == S_UMRG;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (ctl.start) state_next = S_PREP;
      S_PREP: begin
        unique case (cmd)
          CMD_INIT:    state_next = S_FIN;
          CMD_RESERVE: state_next = ({32'b0, addr_q} > e) ? S_FIN : S_RCHK;
          default:     state_next = S_DRD;
        endcase
      end
      S_RCHK:  state_next = (b < e) ? S_DRD : S_FIN;
      S_DRD:   state_next = S_DEVAL;
      S_DEVAL: begin
        if (deval_up) state_next = up_tgt;
        else begin
          unique case (cmd)
            CMD_ALLOC:   state_next = (rnode.st == NODE_FREE) ? S_AW0 : S_ARDL;
            CMD_FREE:    state_next = S_DRD;
            CMD_RESERVE: state_next = (rnode.st == NODE_FREE && !r_leaf) ? S_RW1 : S_RACT;
            CMD_INIT:    state_next = S_FIN;
          endcase
        end
      end
      S_AW0:   state_next = S_AW1;
      S_AW1:   state_next = S_AW2;
      S_AW2:   state_next = S_DRD;
      S_ARDL:  state_next = S_ARDR;
      S_ARDR:  state_next = S_ADEC;
      S_ADEC:  state_next = (la_fit || ra_fit) ? S_DRD : S_UST;
      S_RW1:   state_next = S_RW2;
      S_RW2:   state_next = S_RACT;
      S_RACT:  state_next = r_claim ? up_tgt : S_DRD;
      S_UST:   state_next = (pending && idx == split_idx) ? S_DRD : S_URDR;
      S_URDR:  state_next = S_UMRG;
      S_UMRG:  state_next = up_tgt;
      S_FIN:   if (ctl.res_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port and status outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = nd_q;
    mem_raddr = idx;
    unique case (state)
      S_PREP: if (cmd == CMD_INIT) begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{st: NODE_FREE, sz: region_shift};
      end
      S_DEVAL: begin
        if (cmd == CMD_ALLOC && rnode.st == NODE_FREE && a_take) begin
          mem_we    = 1'b1;
          mem_wdata = '{st: NODE_USED, sz: rnode.sz};
        end else if (cmd == CMD_FREE && rnode.st == NODE_USED) begin
          mem_we    = 1'b1;
          mem_wdata = '{st: NODE_FREE, sz: rnode.sz};
        end
      end
      S_AW0: begin
        mem_we    = 1'b1;
        mem_wdata = '{st: NODE_DIV, sz: nd_q.sz - SZ_W'(1)};
      end
      S_AW1, S_RW1: begin
        mem_we    = 1'b1;
        mem_waddr = lchild;
        mem_wdata = '{st: NODE_FREE, sz: nd_q.sz - SZ_W'(1)};
      end
      S_AW2, S_RW2: begin
        mem_we    = 1'b1;
        mem_waddr = rchild;
        mem_wdata = '{st: NODE_FREE, sz: nd_q.sz - SZ_W'(1)};
      end
      S_RACT: if (r_claim) begin
        mem_we    = 1'b1;
        mem_wdata = '{st: NODE_RSV, sz: nd_q.sz};
      end
      S_UMRG: begin
        mem_we    = 1'b1;
        mem_wdata = merged;
      end
      S_ARDL, S_UST: mem_raddr = lchild;
      S_ARDR, S_URDR: mem_raddr = rchild;
      default: ;
    endcase
  end

  assign sts.idle          = state == S_IDLE;
  assign sts.res_valid     = state == S_FIN;
  assign res.status        = status;
  assign res.block_address = blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
      cmd     <= CMD_INIT;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (ctl.start) begin
          cmd     <= item.cmd;
          need    <= (item.alloc_bytes == '0) ? 32'd1 : item.alloc_bytes;
          addr_q  <= item.address;
          e       <= {32'b0, item.range_end};
          lo      <= {32'b0, region_base};
          hi      <= {32'b0, region_base} + (64'(1) << region_shift);
          idx     <= '0;
          depth   <= '0;
          blk     <= '0;
          pending <= 1'b0;
          status  <= (item.cmd == CMD_ALLOC) ? ST_NO_SPACE : ST_OK;
        end
        S_PREP: if (cmd == CMD_RESERVE) begin
          if ({32'b0, addr_q} > e) status <= ST_RANGE;
          b <= ({32'b0, addr_q} < lo) ? lo : {32'b0, addr_q};
          if (e > hi) e <= hi;
        end
        S_DRD: begin
          span <= hi - lo;
          mid  <= 64'(({1'b0, lo} + {1'b0, hi}) >> 1);
          eb   <= e - b;
        end
        S_DEVAL: begin
          nd_q <= rnode;
          unique case (cmd)
            CMD_ALLOC: if (rnode.st == NODE_FREE && a_take) begin
              blk    <= lo[31:0];
              status <= ST_OK;
            end
            CMD_FREE: begin
              unique case (rnode.st)
                NODE_FREE: status <= ST_NOT_USED;
                NODE_RSV:  status <= ST_RESERVED;
                NODE_USED: status <= ST_OK;
                NODE_DIV: begin
                  if (leaf_lvl) status <= ST_NOT_USED;
                  else if ({32'b0, addr_q} < mid) begin
                    idx <= lchild; depth <= depth + DEPTH_W'(1); hi <= mid;
                  end else begin
                    idx <= rchild; depth <= depth + DEPTH_W'(1); lo <= mid;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
        S_AW2: begin
          idx <= lchild; depth <= depth + DEPTH_W'(1); hi <= mid;
        end
        S_ARDR, S_URDR: lnode <= rnode;
        S_ADEC: begin
          if ((la_fit && ra_fit && la <= ra) || (la_fit && !ra_fit)) begin
            idx <= lchild; depth <= depth + DEPTH_W'(1); hi <= mid;
          end else if (ra_fit) begin
            idx <= rchild; depth <= depth + DEPTH_W'(1); lo <= mid;
          end
        end
        S_RACT: if (!r_claim) begin
          if (e <= mid) begin
            idx <= lchild; depth <= depth + DEPTH_W'(1); hi <= mid;
          end else if (b >= mid) begin
            idx <= rchild; depth <= depth + DEPTH_W'(1); lo <= mid;
          end else begin
            // range straddles the midpoint: left half now, right half later
            split_idx <= idx;
            split_mid <= mid;
            split_hi  <= hi;
            split_e   <= e;
            pending   <= 1'b1;
            idx <= lchild; depth <= depth + DEPTH_W'(1); hi <= mid; e <= mid;
          end
        end
        S_UST: if (pending && idx == split_idx) begin
          pending <= 1'b0;
          idx     <= rchild;
          depth   <= depth + DEPTH_W'(1);
          lo      <= split_mid;
          hi      <= split_hi;
          b       <= split_mid;
          e       <= split_e;
        end
        default: ;
      endcase
      if (up_go && idx != '0) begin
        idx   <= parent;
        depth <= depth - DEPTH_W'(1);
      end
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> depth <= DEPTH_W'(TREE_LEVELS))
    else $error("tree depth out of range");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DRD |-> idx < IDX_W'(NODE_COUNT))
    else $error("node index beyond store");

  a_split_rsv: assert property (@(posedge clk) disable iff (rst)
    pending && state != S_IDLE |-> cmd == CMD_RESERVE)
    else $error("split pending outside reserve");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && !ctl.res_take |=> state == S_FIN && $stable(status))
    else $error("result dropped before transfer");

  a_blk_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && status != ST_OK |-> blk == '0)
    else $error("block address on failed request");

endmodule

[test/tb_buddy_tree_page_allocator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for buddy_tree_page_allocator: random and directed requests,
// a behavioural tree predictor and per-field result checks. Depends on btpa_pkg and the RTL.
module tb_buddy_tree_page_allocator;
  import btpa_pkg::*;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_SHIFT = 1'b1;
  localparam int   MAX_GAP   = 18;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b1;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  buddy_tree_page_allocator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tree predictor: own copy of node store and region registers
  // ---------------------------------------------------------------------------
  node_t       tree [NODE_COUNT];
  logic [63:0] rgn_base  = 64'd0;
  logic [5:0]  rgn_shift = 6'd22;
  logic [63:0] alloc_at;          // block start found by the last alloc walk

  rsp_t        due_rsps [$];      // results still owed by the block
  logic [31:0] live_blocks [$];   // addresses currently allocated
  int          mismatches = 0;
  int          tx_gap_max = MAX_GAP;
  int          rx_gap_max = MAX_GAP;
  int          rx_hold    = 0;    // one long receiver stall, in cycles

  function automatic node_t node_rd(int unsigned i);
    node_t v;
    v = '0;
    if (i < NODE_COUNT) v = tree[i];
    return v;
  endfunction

  function automatic void node_wr(int unsigned i, node_st_t s, logic [5:0] z);
    if (i < NODE_COUNT) tree[i] = {s, z};
  endfunction

  function automatic void node_refold(int unsigned i);
    node_t      l, r;
    logic [5:0] best;
    l = node_rd(2*i+1);
    r = node_rd(2*i+2);
    best = '0;
    if (l.st == NODE_FREE && r.st == NODE_FREE) begin
      node_wr(i, NODE_FREE, l.sz + 6'd1);
    end else begin
      if (l.st == NODE_FREE || l.st == NODE_DIV) best = l.sz;
      if ((r.st == NODE_FREE || r.st == NODE_DIV) && r.sz > best) best = r.sz;
      node_wr(i, NODE_DIV, best);
    end
  endfunction

  function automatic logic [63:0] free_span(node_t v);
    if (v.st == NODE_USED || v.st == NODE_RSV) return 64'd0;
    if (v.st == NODE_DIV && v.sz == 6'd0) return 64'd0;
    return 64'd1 << v.sz;
  endfunction

  function automatic bit alloc_walk(logic [63:0] need, int unsigned i, int depth,
                                    logic [63:0] lo, logic [63:0] hi);
    node_t       v;
    logic [63:0] size, mid, la, ra;
    bit          ok;
    v = node_rd(i);
    size = 64'd1 << v.sz;
    mid = (lo + hi) >> 1;
    ok = 1'b0;
    if (v.st == NODE_FREE) begin
      if (need > size) return 1'b0;
      if (need > size / 2 || size <= PAGE_BYTES || depth >= TREE_LEVELS) begin
        node_wr(i, NODE_USED, v.sz);
        alloc_at = lo;
        return 1'b1;
      end
      node_wr(i, NODE_DIV, v.sz - 6'd1);
      node_wr(2*i+1, NODE_FREE, v.sz - 6'd1);
      node_wr(2*i+2, NODE_FREE, v.sz - 6'd1);
      ok = alloc_walk(need, 2*i+1, depth + 1, lo, mid);
      node_refold(i);
      return ok;
    end
    if (v.st == NODE_DIV) begin
      if (need > size || depth >= TREE_LEVELS) return 1'b0;
      la = free_span(node_rd(2*i+1));
      ra = free_span(node_rd(2*i+2));
      // smaller fitting child wins, left on a tie
      if (la >= need && ra >= need) begin
        if (la <= ra) ok = alloc_walk(need, 2*i+1, depth + 1, lo, mid);
        else ok = alloc_walk(need, 2*i+2, depth + 1, mid, hi);
      end else if (la >= need) begin
        ok = alloc_walk(need, 2*i+1, depth + 1, lo, mid);
      end else if (ra >= need) begin
        ok = alloc_walk(need, 2*i+2, depth + 1, mid, hi);
      end
      node_refold(i);
      return ok;
    end
    return 1'b0;
  endfunction

  function automatic status_t free_walk(logic [63:0] a, int unsigned i, int depth,
                                        logic [63:0] lo, logic [63:0] hi);
    node_t       v;
    logic [63:0] mid;
    status_t     rc;
    v = node_rd(i);
    mid = (lo + hi) >> 1;
    if (v.st == NODE_FREE) return ST_NOT_USED;
    if (v.st == NODE_RSV) return ST_RESERVED;
    if (v.st == NODE_USED) begin
      node_wr(i, NODE_FREE, v.sz);
      return ST_OK;
    end
    if (depth >= TREE_LEVELS) return ST_NOT_USED;
    if (a < mid) rc = free_walk(a, 2*i+1, depth + 1, lo, mid);
    else rc = free_walk(a, 2*i+2, depth + 1, mid, hi);
    node_refold(i);
    return rc;
  endfunction

  function automatic void reserve_walk(logic [63:0] b, logic [63:0] e, int unsigned i,
                                       int depth, logic [63:0] lo, logic [63:0] hi);
    node_t       v;
    logic [63:0] span, mid;
    bit          leaf;
    v = node_rd(i);
    span = hi - lo;
    mid = (lo + hi) >> 1;
    leaf = (span <= PAGE_BYTES) || (depth >= TREE_LEVELS);
    if (v.st == NODE_USED || v.st == NODE_RSV) return;
    if (v.st == NODE_FREE && !leaf) begin
      node_wr(2*i+1, NODE_FREE, v.sz - 6'd1);
      node_wr(2*i+2, NODE_FREE, v.sz - 6'd1);
    end
    // claim whole node at a leaf or when the range covers more than half of it
    if (leaf || e - b > span / 2) begin
      node_wr(i, NODE_RSV, v.sz);
      return;
    end
    if (e <= mid) begin
      reserve_walk(b, e, 2*i+1, depth + 1, lo, mid);
    end else if (b >= mid) begin
      reserve_walk(b, e, 2*i+2, depth + 1, mid, hi);
    end else begin
      reserve_walk(b, mid, 2*i+1, depth + 1, lo, mid);
      reserve_walk(mid, e, 2*i+2, depth + 1, mid, hi);
    end
    node_refold(i);
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t        o;
    logic [63:0] lo, hi, need, a, e;
    lo = rgn_base;
    hi = rgn_base + (64'd1 << rgn_shift);
    a = {32'd0, r.address};
    e = {32'd0, r.range_end};
    o.status = ST_OK;
    o.block_address = '0;
    case (r.cmd)
      CMD_ALLOC: begin
        need = (r.alloc_bytes == 0) ? 64'd1 : {32'd0, r.alloc_bytes};
        if (alloc_walk(need, 0, 0, lo, hi)) o.block_address = alloc_at[31:0];
        else o.status = ST_NO_SPACE;
      end
      CMD_FREE: o.status = free_walk(a, 0, 0, lo, hi);
      CMD_RESERVE: begin
        if (a > e) begin
          o.status = ST_RANGE;
        end else begin
          if (e > hi) e = hi;
          if (a < lo) a = lo;
          if (a < e) reserve_walk(a, e, 0, 0, lo, hi);
        end
      end
      default: node_wr(0, NODE_FREE, rgn_shift);
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_req(cmd_t c, logic [31:0] bytes, logic [31:0] a, logic [31:0] e);
    int   gap;
    rsp_t p;
    int   k;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk) req_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid = 1'b1;
    req = '{cmd: c, alloc_bytes: bytes, address: a, range_end: e};
    do @(posedge clk); while (req_stall);
    // transfer taken: predict in order of acceptance
    p = predict_rsp(req);
    due_rsps.push_back(p);
    if (c == CMD_INIT) live_blocks.delete();
    if (c == CMD_ALLOC && p.status == ST_OK) live_blocks.push_back(p.block_address);
    if (c == CMD_FREE && p.status == ST_OK) begin
      for (k = 0; k < live_blocks.size(); k++) begin
        if (live_blocks[k] == a) begin
          live_blocks.delete(k);
          break;
        end
      end
    end
  endtask

  task automatic drain_rsps();
    @(negedge clk) req_valid = 1'b0;
    while (due_rsps.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);   // idle time before the next test
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BASE) rgn_base = {32'd0, val};
    else rgn_shift = val[5:0];
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver stalls and the checker
  // ---------------------------------------------------------------------------
  initial begin : rx_stalls
    int k;
    forever begin
      if (rx_hold > 0) begin
        k = rx_hold;
        rx_hold = 0;
      end else begin
        k = $urandom_range(0, rx_gap_max);
      end
      if (k > 0) begin
        rsp_stall = 1'b1;
        repeat (k) @(negedge clk);
      end
      rsp_stall = 1'b0;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d addr %h",
                                       rsp.status, rsp.block_address);
      end else begin
        w = due_rsps.pop_front();
        if (rsp.status !== w.status || rsp.block_address !== w.block_address) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch at %0t: status exp %0d got %0d, addr exp %h got %h",
                     $realtime, w.status, rsp.status, w.block_address, rsp.block_address);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_bytes();
    int          sh;
    logic [63:0] lim;
    sh = $urandom_range(0, (rgn_shift > PAGE_SHIFT + 4) ? PAGE_SHIFT + 4 : rgn_shift);
    if ($urandom_range(0, 9) == 0) sh = $urandom_range(0, rgn_shift);
    if (sh >= 32) return $urandom;
    lim = 64'd1 << sh;
    return 32'(({32'd0, $urandom} % lim) + 1);
  endfunction

  task automatic random_traffic(int n);
    int          i, pick;
    logic [63:0] a, len;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_req(CMD_ALLOC, pick_bytes(), $urandom, $urandom);
      end else if (pick < 75 && live_blocks.size() != 0) begin
        send_req(CMD_FREE, $urandom, live_blocks[$urandom_range(0, live_blocks.size()-1)],
                 $urandom);
      end else if (pick < 85) begin
        a = rgn_base + ({32'd0, $urandom} % (64'd1 << rgn_shift));
        len = {32'd0, pick_bytes()};
        send_req(CMD_RESERVE, $urandom, 32'(a), 32'(a + len));
      end else if (pick < 88) begin
        send_req(CMD_INIT, $urandom, $urandom, $urandom);
      end else begin
        // noise: alloc, free or reserve with any field values
        send_req(cmd_t'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [31:0] top;
    top = 32'((64'd1 << rgn_shift) - 1);
    send_req(CMD_INIT, '0, '0, '0);
    send_req(CMD_ALLOC, 32'd0, '0, '0);             // zero bytes means one
    send_req(CMD_ALLOC, 32'd1, '0, '0);
    send_req(CMD_ALLOC, 32'(PAGE_BYTES), '0, '0);
    send_req(CMD_ALLOC, 32'(PAGE_BYTES * 2), '0, '0);  // exact fit in a child
    send_req(CMD_ALLOC, 32'hFFFF_FFFF, '0, '0);     // no space
    send_req(CMD_ALLOC, top + 32'd1, '0, '0);
    send_req(CMD_FREE, '0, live_blocks[0], '0);
    send_req(CMD_FREE, '0, '0, '0);                 // already free
    send_req(CMD_FREE, '0, top, '0);
    send_req(CMD_RESERVE, '0, 32'hFFFF_FFFF, 32'd0); // begin after end
    send_req(CMD_RESERVE, '0, 32'd5, 32'd5);          // empty range
    send_req(CMD_RESERVE, '0, 32'(PAGE_BYTES * 8), 32'(PAGE_BYTES * 9 + 7));
    send_req(CMD_FREE, '0, 32'(PAGE_BYTES * 8), '0); // reserved block
    send_req(CMD_RESERVE, '0, 32'd0, 32'hFFFF_FFFF);  // clamped to the region
    send_req(CMD_ALLOC, 32'd1, '0, '0);
    send_req(CMD_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(CMD_ALLOC, top + 32'd1, '0, '0);       // whole region
    send_req(CMD_FREE, '0, '0, '0);
    send_req(CMD_ALLOC, 32'd1, '0, '0);
    send_req(CMD_FREE, '0, live_blocks[0], '0);     // merges back to the root
    drain_rsps();
  endtask

  task automatic test_setting(logic [31:0] base, logic [5:0] shift, int n);
    write_reg(REG_BASE, base);
    write_reg(REG_SHIFT, {26'd0, shift});
    send_req(CMD_INIT, $urandom, $urandom, $urandom);
    random_traffic(n);
    drain_rsps();
  endtask

  task automatic test_backpressure();
    rx_hold = 400;      // receiver holds off while requests keep coming
    tx_gap_max = 0;
    random_traffic(30);
    tx_gap_max = MAX_GAP;
    drain_rsps();
  endtask

  task automatic test_sender_pause();
    random_traffic(20);
    @(negedge clk) req_valid = 1'b0;
    while (due_rsps.size() != 0) @(posedge clk);
    random_traffic(20);
    drain_rsps();
  endtask

  task automatic test_no_idle();
    tx_gap_max = 0;
    rx_gap_max = 0;
    random_traffic(60);
    tx_gap_max = MAX_GAP;
    rx_gap_max = MAX_GAP;
    drain_rsps();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    test_directed();                               // reset region: base 0, shift 22
    test_setting(32'h0000_0000, 6'd12, 60);        // a single page
    test_setting(32'h8000_0000, 6'd16, 100);
    test_setting(32'hFFFF_FFFF, 6'd32, 100);       // largest region, odd base
    test_setting($urandom & 32'hFFFF_F000, 6'd23, 90);  // leaves above a page
    test_setting(32'h0000_0000, 6'd22, 190);
    test_backpressure();
    test_sender_pause();
    test_no_idle();
    if (due_rsps.size() != 0) mismatches++;
    if (mismatches == 0) $display("buddy_tree_page_allocator regression: pass");
    else $display("buddy_tree_page_allocator regression: fail");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("buddy_tree_page_allocator regression: fail");
    $finish;
  end

endmodule
